/* hdl/msp_pkg.sv */
// Shared types and constants for the multi-channel soft PWM block.
`timescale 1ns / 1ps

package msp_pkg;

  // Field widths fixed by the stream format.
  localparam int PIN_W   = 4;
  localparam int DUTY_W  = 8;
  localparam int LEVEL_W = 16;
  localparam int TICK_W  = 8;
  localparam int CFG_W   = 16;

  // Request kinds carried in tuser.
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PIN_ENABLE = 1'b0;
  localparam logic CFG_TICK_COUNT = 1'b1;

  // Duty codes that force a solid level.
  localparam logic [DUTY_W-1:0] DUTY_SOLID_LOW  = 8'd0;
  localparam logic [DUTY_W-1:0] DUTY_SOLID_HIGH = 8'd255;

  // Scaling divider: PERIOD_SPAN / tick count.
  localparam int QUOT_W = 9;
  localparam logic [QUOT_W-1:0] PERIOD_SPAN = 9'd256;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_out_t;

endpackage

/* hdl/msp_div.sv */
// Restoring divider: constant period span over the tick count, one bit per cycle.
`timescale 1ns / 1ps

module msp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [msp_pkg::TICK_W-1:0]  divisor,
  output msp_pkg::div_out_t           result
);

  localparam int STEPS = msp_pkg::QUOT_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                       busy;
  logic                       done;
  logic [CNT_W-1:0]           cnt;
  logic [msp_pkg::QUOT_W-1:0] rem;
  logic [msp_pkg::QUOT_W-1:0] quot;
  logic [msp_pkg::QUOT_W-1:0] trial;
  logic                       fits;

  // Shift the next dividend bit into the remainder and try a subtract.
  assign trial = {rem[msp_pkg::QUOT_W-2:0], quot[msp_pkg::QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= msp_pkg::PERIOD_SPAN;
    end else if (busy) begin
      rem  <= fits ? (trial - {1'b0, divisor}) : trial;
      quot <= {quot[msp_pkg::QUOT_W-2:0], fits};
    end
  end

  assign result.done = done;
  assign result.quot = quot;

endmodule

/* hdl/multi_channel_soft_pwm.sv */
// Top level of the multi-channel soft PWM generator.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+--------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser: req_type; tdata: pin, duty
//  m_axis   | out | m_axis_tvalid/tready    | tuser: accepted; tdata: levels, running
//  cfg      | in  | cfg_we (no wait)        | cfg_index, cfg_data
//
// A set request goes from accept through the done state to the result. A tick
// on a running block goes through the shared divider for 256 / tick_count,
// one multiply for the compare threshold, then one pin per cycle through the
// compare. A tick on an idle block goes straight to the done state.
// Reset is synchronous; it clears the pin masks, levels and phase counter.
// The input stalls while an item is in work; a held result stalls only the
// final hand-off into the output register.
`timescale 1ns / 1ps

module multi_channel_soft_pwm #(
  parameter int NUM_PINS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [msp_pkg::CFG_W-1:0] cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] pin_index, [11:4] duty_value, [15:12] zero
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] pin_levels, [16] pwm_running, [23:17] zero
  output logic [0:0]  m_axis_tuser    // [0] accepted
);

  // Pins reachable through a 4-bit pin index.
  localparam int LANES = (NUM_PINS < 16) ? NUM_PINS : 16;
  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int THR_W = 16;
  localparam int PROD_W = 2 * msp_pkg::QUOT_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // config registers
  logic [msp_pkg::LEVEL_W-1:0] pin_enable_mask;
  logic [msp_pkg::TICK_W-1:0]  tick_count;

  // PWM state
  logic [msp_pkg::DUTY_W-1:0]  duty_store [LANES];
  logic [LANES-1:0]            active_mask;
  logic [LANES-1:0]            active_next;
  logic [LANES-1:0]            level_register;
  logic [msp_pkg::TICK_W-1:0]  phase_counter;

  // work registers
  logic                        res_accepted;
  logic [msp_pkg::QUOT_W-1:0]  scale;
  logic [THR_W-1:0]            threshold;
  logic [IDX_W-1:0]            walk;

  // request decode
  logic                        in_beat;
  logic                        req_kind;
  logic [msp_pkg::PIN_W-1:0]   pin;
  logic [msp_pkg::DUTY_W-1:0]  duty;
  logic                        pin_ok;
  logic                        solid;
  logic [IDX_W-1:0]            lane;

  logic [msp_pkg::TICK_W-1:0]  eff_ticks;
  logic [msp_pkg::TICK_W:0]    phase_inc;
  logic [PROD_W-1:0]           product;
  logic                        div_start;
  logic                        out_free;
  msp_pkg::div_out_t           div_res;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign req_kind = s_axis_tuser[0];
  assign pin      = s_axis_tdata[3:0];
  assign duty     = s_axis_tdata[11:4];
  assign lane     = pin[IDX_W-1:0];
  assign solid    = (duty == msp_pkg::DUTY_SOLID_LOW) || (duty == msp_pkg::DUTY_SOLID_HIGH);
  assign pin_ok   = ({1'b0, pin} < 5'(LANES)) && pin_enable_mask[pin];

  // tick_count of zero behaves as one
  assign eff_ticks = (tick_count == '0) ? msp_pkg::TICK_W'(1) : tick_count;
  assign phase_inc = {1'b0, phase_counter} + 1'b1;
  assign product   = PROD_W'(phase_inc) * PROD_W'(scale);

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign div_start     = in_beat && (req_kind == msp_pkg::REQ_TICK) && (active_mask != '0);

  msp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (eff_ticks),
    .result  (div_res)
  );

  // Active mask after a set request on an enabled pin.
  always_comb begin
    active_next = active_mask;
    active_next[lane] = !solid;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = div_start ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_WALK;
      ST_WALK: begin
        if (walk == IDX_W'(LANES - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      pin_enable_mask <= '0;
      tick_count      <= msp_pkg::TICK_W'(16);
      active_mask     <= '0;
      level_register  <= '0;
      phase_counter   <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          msp_pkg::CFG_PIN_ENABLE: pin_enable_mask <= cfg_data;
          msp_pkg::CFG_TICK_COUNT: tick_count      <= cfg_data[msp_pkg::TICK_W-1:0];
          default: ;
        endcase
      end

      // Apply a set request at the accepting edge; levels of PWM pins wait
      // for the next tick.
      if (in_beat && (req_kind == msp_pkg::REQ_SET) && pin_ok) begin
        active_mask <= active_next;
        if (solid) begin
          level_register[lane] <= (duty == msp_pkg::DUTY_SOLID_HIGH);
        end
        if (active_next == '0) begin
          phase_counter <= '0;
        end
      end

      // Compare one pin per cycle; advance the phase after the last pin.
      if (state == ST_WALK) begin
        if (active_mask[walk]) begin
          level_register[walk] <= {{(THR_W - msp_pkg::DUTY_W){1'b0}}, duty_store[walk]}
                                  >= threshold;
        end
        if (walk == IDX_W'(LANES - 1)) begin
          phase_counter <= (phase_inc >= {1'b0, eff_ticks}) ? '0
                                                            : phase_inc[msp_pkg::TICK_W-1:0];
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_accepted <= (req_kind == msp_pkg::REQ_TICK) || pin_ok;
      if ((req_kind == msp_pkg::REQ_SET) && pin_ok && !solid) begin
        duty_store[lane] <= duty;
      end
    end
    if (div_res.done) begin
      scale <= div_res.quot;
    end
    if (state == ST_MUL) begin
      threshold <= product[THR_W-1:0];
      walk      <= '0;
    end else if (state == ST_WALK) begin
      walk <= walk + 1'b1;
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tuser[0]     <= res_accepted;
      m_axis_tdata[15:0]  <= 16'(level_register);
      m_axis_tdata[16]    <= (active_mask != '0);
      m_axis_tdata[23:17] <= '0;
    end
  end

`ifndef SYNTHESIS
  // An idle PWM engine always holds its phase at zero.
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (active_mask == '0) |-> (phase_counter == '0))
    else $error("phase counter nonzero with no active pin");

  // The divider reports only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide step");

  // A pin walk only runs when some pin is in PWM mode.
  a_walk_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (active_mask != '0))
    else $error("pin walk with no active pin");
`endif

endmodule

/* tb/multi_channel_soft_pwm_tb.sv */
// Stream testbench for the multi-channel soft PWM block, with a predicting scoreboard.
`timescale 1ns / 1ps

module multi_channel_soft_pwm_tb;

  // One result beat as the block should present it.
  typedef struct packed {
    logic        accepted;
    logic [15:0] levels;
    logic        running;
  } pwm_status_t;

  // Tracks pin modes, duties, levels and the phase counter; compares every
  // result beat against the oldest predicted status.
  class pwm_level_checker;
    logic [15:0] enable_mask;
    logic [7:0]  period_ticks;
    logic [7:0]  duty_mem [16];
    logic [15:0] pwm_mask;
    logic [15:0] level_bits;
    logic [7:0]  phase;
    pwm_status_t pending_status [$];
    int          mismatch_count;

    function new();
      enable_mask    = '0;
      period_ticks   = 8'd16;
      pwm_mask       = '0;
      level_bits     = '0;
      phase          = '0;
      mismatch_count = 0;
      foreach (duty_mem[i]) duty_mem[i] = '0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == msp_pkg::CFG_PIN_ENABLE) enable_mask = data;
      else period_ticks = data[7:0];
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    function void flag(string what, logic [31:0] exp_val, logic [31:0] act_val);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, exp_val,
                 act_val);
    endfunction

    // Advance the model by one accepted request and queue its status.
    function void note_request(logic req, logic [3:0] pin, logic [7:0] duty);
      int          ticks;
      int          threshold;
      int          next_phase;
      pwm_status_t st;
      st.accepted = 1'b1;
      if (req == msp_pkg::REQ_TICK) begin
        ticks = (period_ticks == 0) ? 1 : int'(period_ticks);
        if (pwm_mask != 0) begin
          for (int i = 0; i < 16; i++) begin
            if (pwm_mask[i]) begin
              threshold     = int'(duty_mem[i]) / (256 / ticks);
              level_bits[i] = (int'(phase) < threshold);
            end
          end
          next_phase = int'(phase) + 1;
          if (next_phase >= ticks) next_phase = 0;
          phase = next_phase[7:0];
        end
      end else if (!enable_mask[pin]) begin
        st.accepted = 1'b0;
      end else begin
        if (duty == msp_pkg::DUTY_SOLID_LOW || duty == msp_pkg::DUTY_SOLID_HIGH) begin
          pwm_mask[pin]   = 1'b0;
          level_bits[pin] = (duty == msp_pkg::DUTY_SOLID_HIGH);
        end else begin
          pwm_mask[pin] = 1'b1;
          duty_mem[pin] = duty;
        end
        if (pwm_mask == 0) phase = '0;
      end
      st.levels  = level_bits;
      st.running = (pwm_mask != 0);
      pending_status.push_back(st);
    endfunction

    function void check_status(logic acc, logic [15:0] lev, logic run);
      pwm_status_t st;
      if (pending_status.size() == 0) begin
        flag("unexpected beat", 32'h0, {14'h0, acc, lev, run});
        return;
      end
      st = pending_status.pop_front();
      if (acc !== st.accepted) flag("accepted", st.accepted, acc);
      if (lev !== st.levels)   flag("pin_levels", st.levels, lev);
      if (run !== st.running)  flag("pwm_running", st.running, run);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [3:0] pin_index, [11:4] duty_value, [15:12] zero
  logic [0:0]  s_axis_tuser;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] pin_levels, [16] pwm_running, [23:17] zero
  logic [0:0]  m_axis_tuser;   // [0] accepted

  // Once set, both sides stop idling for the tail of the run.
  bit calm;

  pwm_level_checker board;

  multi_channel_soft_pwm dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run (about 1600 beats, each with the
  // block's own work plus an idle gap and a result stall).
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: hold tready low in random bursts, with open stretches between;
  // stop stalling once the tail of the run begins.
  initial begin
    int  hold;
    bit  stall;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        stall = !calm && ($urandom_range(0, 2) == 0);
        hold  = stall ? $urandom_range(0, 9) : $urandom_range(0, 19);
        m_axis_tready <= !stall;
      end
    end
  end

  // Sample result beats at the rising edge and check them in order.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_status(m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[16]);
  end

  // Present one request, optionally after an idle burst, and hold it until
  // the block takes it. tvalid stays high on return so back-to-back beats
  // need no dip.
  task automatic send_req(logic req, logic [3:0] pin, logic [7:0] duty);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'h0, duty, pin};
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(req, pin, duty);
  endtask

  // Pin and duty are don't-care on a tick; randomize them anyway.
  task automatic send_tick();
    send_req(msp_pkg::REQ_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  // Drop tvalid and wait until every predicted beat has come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Single-cycle register write; only called with the block drained.
  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.write_reg(idx, data);
  endtask

  // Mostly well-formed traffic: duty changes on random pins mixed with runs
  // of ticks so the phase counter walks through whole periods.
  task automatic random_phase(int count);
    int          sel;
    logic [7:0]  duty;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        send_tick();
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0)      duty = msp_pkg::DUTY_SOLID_LOW;
        else if (sel == 1) duty = msp_pkg::DUTY_SOLID_HIGH;
        else               duty = 8'($urandom_range(1, 254));
        send_req(msp_pkg::REQ_SET, 4'($urandom_range(0, 15)), duty);
      end
    end
  endtask

  initial begin
    logic [15:0] mask;
    logic [7:0]  period;
    board         = new();
    calm          = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = msp_pkg::CFG_PIN_ENABLE;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = msp_pkg::REQ_SET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Out of reset no pin is enabled: set is refused, tick on an idle block.
    send_req(msp_pkg::REQ_SET, 4'd3, 8'd100);
    send_tick();
    drain();

    write_reg(msp_pkg::CFG_PIN_ENABLE, 16'hFFFF);
    write_reg(msp_pkg::CFG_TICK_COUNT, 16'd16);
    // Solid high, solid low, the smallest and largest PWM duties, then a solid
    // pin moved to PWM and a pin switched between solid levels.
    send_req(msp_pkg::REQ_SET, 4'd0, msp_pkg::DUTY_SOLID_HIGH);
    send_req(msp_pkg::REQ_SET, 4'd15, msp_pkg::DUTY_SOLID_LOW);
    send_req(msp_pkg::REQ_SET, 4'd1, 8'd1);
    send_req(msp_pkg::REQ_SET, 4'd2, 8'd254);
    send_req(msp_pkg::REQ_SET, 4'd15, 8'd128);
    send_req(msp_pkg::REQ_SET, 4'd4, msp_pkg::DUTY_SOLID_HIGH);
    send_req(msp_pkg::REQ_SET, 4'd4, msp_pkg::DUTY_SOLID_LOW);
    repeat (3) send_tick();
    drain();

    // Longest period; disable the upper pins while pin 15 keeps running.
    write_reg(msp_pkg::CFG_TICK_COUNT, 16'd255);
    write_reg(msp_pkg::CFG_PIN_ENABLE, 16'h00FF);
    repeat (2) send_tick();
    send_req(msp_pkg::REQ_SET, 4'd15, 8'd50);
    send_req(msp_pkg::REQ_SET, 4'd2, 8'd200);
    drain();

    // Shrink the period below the current phase so the counter wraps early.
    write_reg(msp_pkg::CFG_TICK_COUNT, 16'd2);
    repeat (2) send_tick();
    drain();

    // A period of zero behaves as one; then stop every PWM pin.
    write_reg(msp_pkg::CFG_TICK_COUNT, 16'd0);
    repeat (2) send_tick();
    drain();
    write_reg(msp_pkg::CFG_PIN_ENABLE, 16'hFFFF);
    send_req(msp_pkg::REQ_SET, 4'd1, msp_pkg::DUTY_SOLID_LOW);
    send_req(msp_pkg::REQ_SET, 4'd2, msp_pkg::DUTY_SOLID_LOW);
    send_req(msp_pkg::REQ_SET, 4'd15, msp_pkg::DUTY_SOLID_LOW);
    send_tick();
    drain();

    // Random phases, each under a fresh setting; the last one runs calm.
    for (int ph = 0; ph < 15; ph++) begin
      case ($urandom_range(0, 4))
        0:       mask = 16'hFFFF;
        1:       mask = 16'h0000;
        default: mask = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 3))
        0: period = 8'($urandom_range(1, 8));
        1: begin
          case ($urandom_range(0, 2))
            0:       period = 8'd0;
            1:       period = 8'd1;
            default: period = 8'd255;
          endcase
        end
        2: period = 8'($urandom_range(0, 255));
        default: period = 8'($urandom_range(9, 40));
      endcase
      write_reg(msp_pkg::CFG_PIN_ENABLE, mask);
      write_reg(msp_pkg::CFG_TICK_COUNT, {8'h00, period});
      if (ph == 14) calm = 1'b1;
      random_phase(50);
      // Pause mid-phase until every result is back, then carry on.
      if (ph == 7) drain();
      random_phase(52);
      drain();
    end

    repeat (40) @(posedge clk);
    if (board.pending() != 0) board.flag("missing beats", 32'h0, board.pending());
    if (board.mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
